### rtl/core/rrts_pkg.sv
package rrts_pkg;

   // Sizes of the task space and the ready queue
   localparam int TASK_SLOTS = 64;
   localparam int ID_W       = 6;
   localparam int CNT_W      = 7;
   localparam int ADDR_W     = 3;

   typedef logic [ID_W-1:0]  task_id_type;
   typedef logic [CNT_W-1:0] count_type;

   // Command codes
   typedef enum logic [1:0] {
      CMD_READY = 2'd0,
      CMD_SCHED = 2'd1,
      CMD_EXIT  = 2'd2
   } command_type;

   // Per-task life cycle
   typedef enum logic [1:0] {
      ST_UNUSED  = 2'd0,
      ST_READY   = 2'd1,
      ST_RUNNING = 2'd2,
      ST_DEAD    = 2'd3
   } task_state_type;

   // Register byte addresses
   localparam logic [ADDR_W-1:0] ADDR_SCHED_ON = 3'd0;

   // Queue control from the scheduler
   typedef struct packed {
      logic        push;
      logic        pop;
      task_id_type push_id;
   } queue_ctrl_type;

   // Queue status back to the scheduler
   typedef struct packed {
      task_id_type head_id;
      count_type   count;
      count_type   count_next;
   } queue_stat_type;

endpackage

### rtl/core/rrts_ready_queue.sv
module rrts_ready_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  rrts_pkg::queue_ctrl_type ctrl,
   output rrts_pkg::queue_stat_type stat
);
   import rrts_pkg::*;

   task_id_type mem [TASK_SLOTS];
   task_id_type head_ff, head_in;
   task_id_type tail_ff, tail_in;
   count_type   count_ff, count_in;
   task_id_type rd_ff;

   // Pointer and fill count update; pointers wrap at the queue depth
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctrl.pop) begin
         head_in = head_ff + 1'b1;
      end
      if (ctrl.push) begin
         tail_in = tail_ff + 1'b1;
      end
      count_in = count_ff + count_type'(ctrl.push) - count_type'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage: one write port, registered read of the head entry
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[tail_ff] <= ctrl.push_id;
      end
      rd_ff <= mem[head_ff];
   end

   assign stat.head_id    = rd_ff;
   assign stat.count      = count_ff;
   assign stat.count_next = count_in;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= count_type'(TASK_SLOTS))
      else $error("ready queue count above depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> (count_ff < count_type'(TASK_SLOTS)) || ctrl.pop)
      else $error("push into full ready queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctrl.pop |-> count_ff != '0)
      else $error("pop from empty ready queue");

endmodule

### rtl/core/round_robin_task_scheduler.sv
// Flow: an accepted command is captured into cmd_ff and tid_ff as busy rises;
//   the decision made while busy is registered into the result word.
// No new command is accepted while busy; busy is high for the cycle in which
//   the registered head read of the ready-queue memory is consumed.
// Reset: queue empty, idle task 0 running, scheduling disabled; no clearing pass.
// The receiver cannot stall: each result word is shown for exactly one cycle.
module round_robin_task_scheduler (
   input  logic                        clock,
   input  logic                        reset,
   // command channel
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_command,
   input  rrts_pkg::task_id_type       req_task_id,
   // result channel
   output logic                        rsp_valid,
   output logic                        rsp_switch_flag,
   output rrts_pkg::task_id_type       rsp_prev_task,
   output rrts_pkg::task_id_type       rsp_running_task,
   output rrts_pkg::count_type         rsp_queue_count,
   output logic                        rsp_overflow,
   // register port
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rrts_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import rrts_pkg::*;

   logic           busy_ff;
   command_type    cmd_ff;
   task_id_type    tid_ff;
   logic           on_ff;
   task_id_type    cur_ff, cur_in;
   task_state_type cur_state_ff, cur_state_in;

   logic           rsp_valid_ff;
   logic           rsp_switch_ff;
   task_id_type    rsp_prev_ff;
   task_id_type    rsp_run_ff;
   count_type      rsp_count_ff;
   logic           rsp_ovf_ff;

   logic           ovf_in;
   logic           accept;
   queue_ctrl_type qctrl;
   queue_stat_type qstat;

   assign accept = start && !busy_ff;

   // Register port
   assign pready = 1'b1;
   assign prdata = (paddr == ADDR_SCHED_ON) ? {31'b0, on_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         on_ff <= 1'b0;
      end else if (psel && penable && pwrite && (paddr == ADDR_SCHED_ON)) begin
         on_ff <= pwdata[0];
      end
   end

   // Command capture
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= accept;
      end
      if (accept) begin
         cmd_ff <= command_type'(req_command);
         tid_ff <= req_task_id;
      end
   end

   // Scheduling decision; only the current task's state is ever consulted
   always_comb begin
      task_state_type st_eff;
      logic           go;
      task_id_type    next_id;
      st_eff       = cur_state_ff;
      go           = 1'b0;
      next_id      = '0;
      cur_in       = cur_ff;
      cur_state_in = cur_state_ff;
      ovf_in       = 1'b0;
      qctrl        = '0;
      if (busy_ff) begin
         unique case (cmd_ff)
            CMD_READY: begin
               if ({1'b0, tid_ff} < count_type'(TASK_SLOTS)) begin
                  if (tid_ff == cur_ff) begin
                     cur_state_in = ST_READY;
                  end
                  if (qstat.count < count_type'(TASK_SLOTS)) begin
                     qctrl.push    = 1'b1;
                     qctrl.push_id = tid_ff;
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
            end
            CMD_SCHED, CMD_EXIT: begin
               if (cmd_ff == CMD_EXIT) begin
                  st_eff       = ST_DEAD;
                  cur_state_in = ST_DEAD;
               end
               if (on_ff) begin
                  priority if (qstat.count != '0) begin
                     qctrl.pop = 1'b1;
                     next_id   = qstat.head_id;
                     go        = 1'b1;
                  end else if (st_eff == ST_DEAD || cur_ff != '0) begin
                     go = 1'b1;
                  end else begin
                     // live idle task and nothing ready: keep it
                     go = 1'b0;
                  end
                  if (go) begin
                     // a still-running task goes back to the ready queue tail
                     if (st_eff == ST_RUNNING) begin
                        qctrl.push    = 1'b1;
                        qctrl.push_id = cur_ff;
                     end
                     cur_in       = next_id;
                     cur_state_in = ST_RUNNING;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         cur_state_ff <= ST_RUNNING;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         cur_state_ff <= cur_state_in;
         rsp_valid_ff <= busy_ff;
      end
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         rsp_switch_ff <= (cur_in != cur_ff);
         rsp_prev_ff   <= cur_ff;
         rsp_run_ff    <= cur_in;
         rsp_count_ff  <= qstat.count_next;
         rsp_ovf_ff    <= ovf_in;
      end
   end

   rrts_ready_queue u_queue (
      .clock (clock),
      .reset (reset),
      .ctrl  (qctrl),
      .stat  (qstat)
   );

   assign busy             = busy_ff;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_switch_flag  = rsp_switch_ff;
   assign rsp_prev_task    = rsp_prev_ff;
   assign rsp_running_task = rsp_run_ff;
   assign rsp_queue_count  = rsp_count_ff;
   assign rsp_overflow     = rsp_ovf_ff;

   // Checks
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff && rsp_valid_ff)
      else $error("command not finished in one busy cycle");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_count_ff == count_type'(TASK_SLOTS))
      else $error("overflow reported with room in the queue");

   a_switch_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_switch_ff |-> cur_state_ff == ST_RUNNING)
      else $error("switched to a task not marked running");

   a_ready_no_switch: assert property (@(posedge clock) disable iff (reset)
      busy_ff && cmd_ff == CMD_READY |=> !rsp_switch_ff)
      else $error("make-ready changed the running task");

endmodule
